// ----- hw/rtl/efhp_pkg.sv -----
// ----------------------------------------------------------------------------
// efhp_pkg - Ethernet frame header parser package
// Shared widths, header offsets, status codes and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package efhp_pkg;

   // Byte offsets within the frame
   localparam logic [15:0] MAC_FIRST      = 16'd6;
   localparam logic [15:0] MAC_LAST       = 16'd11;
   localparam logic [15:0] ETYPE_HI       = 16'd12;
   localparam logic [15:0] ETYPE_LO       = 16'd13;
   localparam logic [15:0] VERSION_OFS    = 16'd14;
   localparam logic [15:0] TYPE_OFS       = 16'd15;
   localparam logic [15:0] SEQ_HI         = 16'd16;
   localparam logic [15:0] SEQ_LO         = 16'd17;
   localparam logic [15:0] FLAGS_OFS      = 16'd18;
   localparam logic [15:0] LEN_HI         = 16'd19;
   localparam logic [15:0] LEN_LO         = 16'd20;
   localparam logic [15:0] HDR_END        = 16'd21;
   localparam logic [15:0] INDEX_MAX      = 16'hFFFF;

   // Result data layout
   localparam int RSP_DATA_W = 112;

   // Status codes reported on the last byte
   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_TOO_SHORT     = 3'd1,
      STATUS_BAD_ETHERTYPE = 3'd2,
      STATUS_BAD_VERSION   = 3'd3,
      STATUS_LEN_EXCEEDS   = 3'd4
   } status_type;

   // Configuration register indexes
   localparam logic CSR_ETHERTYPE = 1'b0;
   localparam logic CSR_VERSION   = 1'b1;

endpackage

// ----- hw/rtl/ethernet_frame_header_parser_core.sv -----
// ----------------------------------------------------------------------------
// ethernet_frame_header_parser_core - Ethernet frame header parser
// Parses a byte stream, captures header fields, marks payload, checks frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one frame byte per request in req_tdata, req_tlast on the final
//            byte of the frame.
//   rsp_*  : exactly one response per request: payload byte, status and the
//            header fields captured so far; rsp_tuser marks a payload byte and
//            rsp_tlast marks the response to the final byte of the frame.
//   csr_*  : write port for the expected EtherType (index 0) and the expected
//            version byte (index 1); write only while the stream is idle.
// Output: the response is held in the output register, valid in the cycle after the request is taken.
// Throughput: one byte per clock while the response side keeps up; the header capture and all checks fit in
//   one pass of logic between the frame state and the output register.
// Stall: when rsp_tready is low with a response waiting, req_tready drops;
//   it rises again in the cycle the response is taken.
// Reset: clears the frame state, both expected values and the output valid.
// After the final byte of a frame the frame state clears for the next frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ethernet_frame_header_parser_core (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] rx_byte
   input  logic                              req_tlast,   // end_of_frame
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] payload_byte, [8] accepted, [11:9] status, [59:12] source_mac,
   // [67:60] message_type, [83:68] sequence_res, [91:84] flag_bits,
   // [107:92] payload_length, [111:108] zero
   output logic [efhp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,   // payload_valid
   output logic                              rsp_tlast,   // frame_done
   // configuration port
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [15:0]                       csr_wdata
);

   // Configuration registers
   logic [15:0] exp_etype_ff;
   logic [7:0]  exp_version_ff;

   // Frame state
   logic [15:0] byte_index_ff, byte_index_in;
   logic [47:0] mac_ff, mac_in;
   logic [15:0] etype_ff, etype_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] seq_ff, seq_in;
   logic [7:0]  flags_ff, flags_in;
   logic [15:0] len_ff, len_in;

   // Output register
   logic                            rsp_valid_ff;
   logic [efhp_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                            rsp_user_ff, rsp_user_in;
   logic                            rsp_last_ff;

   logic                  req_fire;
   logic                  checks_ok;
   logic                  pay_valid;
   logic [16:0]           pay_end;
   logic [16:0]           frame_bytes;
   efhp_pkg::status_type  status;
   logic                  accepted;
   logic [7:0]            pay_byte;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // Capture header bytes by offset
   always_comb begin
      mac_in     = mac_ff;
      etype_in   = etype_ff;
      version_in = version_ff;
      type_in    = type_ff;
      seq_in     = seq_ff;
      flags_in   = flags_ff;
      len_in     = len_ff;
      if (byte_index_ff inside {[efhp_pkg::MAC_FIRST:efhp_pkg::MAC_LAST]}) begin
         mac_in = {mac_ff[39:0], req_tdata};
      end else if (byte_index_ff inside {efhp_pkg::ETYPE_HI, efhp_pkg::ETYPE_LO}) begin
         etype_in = {etype_ff[7:0], req_tdata};
      end else if (byte_index_ff == efhp_pkg::VERSION_OFS) begin
         version_in = req_tdata;
      end else if (byte_index_ff == efhp_pkg::TYPE_OFS) begin
         type_in = req_tdata;
      end else if (byte_index_ff inside {efhp_pkg::SEQ_HI, efhp_pkg::SEQ_LO}) begin
         seq_in = {seq_ff[7:0], req_tdata};
      end else if (byte_index_ff == efhp_pkg::FLAGS_OFS) begin
         flags_in = req_tdata;
      end else if (byte_index_ff inside {efhp_pkg::LEN_HI, efhp_pkg::LEN_LO}) begin
         len_in = {len_ff[7:0], req_tdata};
      end
   end

   // Payload window and frame checks, using the updated capture values
   always_comb begin
      checks_ok   = (etype_in == exp_etype_ff) && (version_in == exp_version_ff);
      pay_end     = {1'b0, len_in} + {1'b0, efhp_pkg::HDR_END};
      frame_bytes = {1'b0, byte_index_ff} + 17'd1;
      pay_valid   = (byte_index_ff >= efhp_pkg::HDR_END) &&
                    ({1'b0, byte_index_ff} < pay_end) && checks_ok;

      status = efhp_pkg::STATUS_OK;
      if (req_tlast) begin
         if (frame_bytes < {1'b0, efhp_pkg::HDR_END}) begin
            status = efhp_pkg::STATUS_TOO_SHORT;
         end else if (etype_in != exp_etype_ff) begin
            status = efhp_pkg::STATUS_BAD_ETHERTYPE;
         end else if (version_in != exp_version_ff) begin
            status = efhp_pkg::STATUS_BAD_VERSION;
         end else if (pay_end > frame_bytes) begin
            status = efhp_pkg::STATUS_LEN_EXCEEDS;
         end
      end
      accepted = req_tlast && (status == efhp_pkg::STATUS_OK);
      pay_byte = pay_valid ? req_tdata : 8'd0;

      rsp_data_in = {4'd0, len_in, flags_in, seq_in, type_in, mac_in,
                     status, accepted, pay_byte};
      rsp_user_in = pay_valid;
   end

   // Advance the byte counter, saturate, clear after the last byte
   always_comb begin
      if (req_tlast) begin
         byte_index_in = '0;
      end else if (byte_index_ff != efhp_pkg::INDEX_MAX) begin
         byte_index_in = byte_index_ff + 16'd1;
      end else begin
         byte_index_in = byte_index_ff;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_etype_ff   <= '0;
         exp_version_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            efhp_pkg::CSR_ETHERTYPE: exp_etype_ff   <= csr_wdata;
            efhp_pkg::CSR_VERSION:   exp_version_ff <= csr_wdata[7:0];
            default:                 exp_etype_ff   <= exp_etype_ff;
         endcase
      end
   end

   // Frame state: update on each request, clear after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         mac_ff        <= '0;
         etype_ff      <= '0;
         version_ff    <= '0;
         type_ff       <= '0;
         seq_ff        <= '0;
         flags_ff      <= '0;
         len_ff        <= '0;
      end else if (req_fire) begin
         byte_index_ff <= byte_index_in;
         if (req_tlast) begin
            mac_ff     <= '0;
            etype_ff   <= '0;
            version_ff <= '0;
            type_ff    <= '0;
            seq_ff     <= '0;
            flags_ff   <= '0;
            len_ff     <= '0;
         end else begin
            mac_ff     <= mac_in;
            etype_ff   <= etype_in;
            version_ff <= version_in;
            type_ff    <= type_in;
            seq_ff     <= seq_in;
            flags_ff   <= flags_in;
            len_ff     <= len_in;
         end
      end
   end

   // Output register: load on request, drop valid when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= req_tlast;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- dv/ethernet_frame_header_parser_core_tb.sv -----
// ----------------------------------------------------------------------------
// ethernet_frame_header_parser_core_tb - frame header parser testbench
// Streams Ethernet frames byte by byte into the parser and checks every
// response against a cycle-free model of the header capture and frame checks.
// A short table of hand-built bytes comes first. Random frames follow: mostly
// well-formed headers with random content, plus truncated frames, noise,
// mismatched headers and declared lengths past the frame end. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ethernet_frame_header_parser_core_tb;

   // One parser response, split into its fields
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        frame_done;
      logic        accepted;
      logic [2:0]  status;
      logic [47:0] source_mac;
      logic [7:0]  message_type;
      logic [15:0] sequence_res;
      logic [7:0]  flag_bits;
      logic [15:0] payload_length;
   } parse_result_type;

   // One directed request; a typed row carries its response, others use the model
   typedef struct packed {
      logic [7:0]       rx;
      logic             eof;
      logic             typed;
      parse_result_type want;
   } byte_row_type;

   localparam int QUIET_LIMIT  = 1000;
   localparam int RANDOM_ITEMS = 1750;

   // Directed bytes: a one-byte frame, then a minimal header built from extremes.
   // Registers hold 0xFFFF / 0xFF, so the short frame also has a bad EtherType
   // and must still report too short.
   localparam byte_row_type DIRECTED_ROWS [22] = '{
      '{8'hFF, 1'b1, 1'b1, '{payload_byte: 8'h00, payload_valid: 1'b0,
                             frame_done: 1'b1, accepted: 1'b0,
                             status: efhp_pkg::STATUS_TOO_SHORT, source_mac: 48'h0,
                             message_type: 8'h00, sequence_res: 16'h0000,
                             flag_bits: 8'h00, payload_length: 16'h0000}},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, '0},
      '{8'hAA, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h12, 1'b0, 1'b0, '0},
      '{8'h34, 1'b0, 1'b0, '0},
      '{8'h56, 1'b0, 1'b0, '0},
      '{8'hAB, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{payload_byte: 8'h00, payload_valid: 1'b0,
                             frame_done: 1'b1, accepted: 1'b1,
                             status: efhp_pkg::STATUS_OK,
                             source_mac: 48'hFF00_1234_56AB,
                             message_type: 8'h00, sequence_res: 16'hFF01,
                             flag_bits: 8'h80, payload_length: 16'h0000}}
   };

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata  = 8'h00;
   logic                            req_tlast  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [efhp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_we     = 1'b0;
   logic                            csr_index  = efhp_pkg::CSR_ETHERTYPE;
   logic [15:0]                     csr_wdata  = 16'h0000;

   // Model copy of registers and frame state
   logic [15:0] cfg_ethertype = '0;
   logic [7:0]  cfg_version   = '0;
   logic [15:0] byte_pos      = '0;
   logic [47:0] mac_acc       = '0;
   logic [15:0] etype_acc     = '0;
   logic [7:0]  version_acc   = '0;
   logic [7:0]  type_acc      = '0;
   logic [15:0] seq_acc       = '0;
   logic [7:0]  flags_acc     = '0;
   logic [15:0] len_acc       = '0;

   parse_result_type parsed_bytes[$];
   int               failures     = 0;
   int               gap_pct      = 0;
   int               stall_pct    = 0;
   int               random_items = 0;
   int               quiet_cycles = 0;

   ethernet_frame_header_parser_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Advance the frame state by one byte and return the response it causes
   function automatic parse_result_type parse_byte(input logic [7:0] b, input logic eof);
      parse_result_type     r;
      logic [15:0]          idx;
      logic                 header_ok;
      efhp_pkg::status_type st;
      idx = byte_pos;
      if (idx >= efhp_pkg::MAC_FIRST && idx <= efhp_pkg::MAC_LAST) begin
         mac_acc = {mac_acc[39:0], b};
      end else if (idx == efhp_pkg::ETYPE_HI || idx == efhp_pkg::ETYPE_LO) begin
         etype_acc = {etype_acc[7:0], b};
      end else if (idx == efhp_pkg::VERSION_OFS) begin
         version_acc = b;
      end else if (idx == efhp_pkg::TYPE_OFS) begin
         type_acc = b;
      end else if (idx == efhp_pkg::SEQ_HI || idx == efhp_pkg::SEQ_LO) begin
         seq_acc = {seq_acc[7:0], b};
      end else if (idx == efhp_pkg::FLAGS_OFS) begin
         flags_acc = b;
      end else if (idx == efhp_pkg::LEN_HI || idx == efhp_pkg::LEN_LO) begin
         len_acc = {len_acc[7:0], b};
      end
      header_ok = (etype_acc == cfg_ethertype) && (version_acc == cfg_version);
      // first failing check wins; a saturated counter reads as 65536 bytes
      st = efhp_pkg::STATUS_OK;
      if (eof) begin
         if (int'(idx) + 1 < int'(efhp_pkg::HDR_END)) begin
            st = efhp_pkg::STATUS_TOO_SHORT;
         end else if (etype_acc != cfg_ethertype) begin
            st = efhp_pkg::STATUS_BAD_ETHERTYPE;
         end else if (version_acc != cfg_version) begin
            st = efhp_pkg::STATUS_BAD_VERSION;
         end else if (int'(efhp_pkg::HDR_END) + int'(len_acc) > int'(idx) + 1) begin
            st = efhp_pkg::STATUS_LEN_EXCEEDS;
         end
      end
      r.payload_valid  = (idx >= efhp_pkg::HDR_END) && header_ok &&
                         (int'(idx) < int'(efhp_pkg::HDR_END) + int'(len_acc));
      r.payload_byte   = r.payload_valid ? b : 8'h00;
      r.frame_done     = eof;
      r.accepted       = eof && (st == efhp_pkg::STATUS_OK);
      r.status         = st;
      r.source_mac     = mac_acc;
      r.message_type   = type_acc;
      r.sequence_res   = seq_acc;
      r.flag_bits      = flags_acc;
      r.payload_length = len_acc;
      // clear after the last byte, otherwise step the saturating counter
      if (eof) begin
         byte_pos    = '0;
         mac_acc     = '0;
         etype_acc   = '0;
         version_acc = '0;
         type_acc    = '0;
         seq_acc     = '0;
         flags_acc   = '0;
         len_acc     = '0;
      end else if (byte_pos != efhp_pkg::INDEX_MAX) begin
         byte_pos = byte_pos + 16'd1;
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   // Drive one request, waiting out random sender gaps, and log its response
   task automatic send_byte(input logic [7:0] b, input logic eof, input logic typed,
                            input parse_result_type want);
      parse_result_type modeled;
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eof;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      modeled = parse_byte(b, eof);
      parsed_bytes.push_back(typed ? want : modeled);
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] fr[$]);
      foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1, 1'b0, '0);
   endtask

   // Append a 21-byte header with random addresses, type, sequence and flags
   function automatic void build_header(ref logic [7:0] fr[$], input logic [15:0] etype,
                                        input logic [7:0] ver, input logic [15:0] plen);
      repeat (12) fr.push_back(8'($urandom));
      fr.push_back(etype[15:8]);
      fr.push_back(etype[7:0]);
      fr.push_back(ver);
      repeat (4) fr.push_back(8'($urandom));
      fr.push_back(plen[15:8]);
      fr.push_back(plen[7:0]);
   endfunction

   // Drain all responses, then hold the stream idle for the output stage
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (parsed_bytes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
   endtask

   // Write one register, then release the write enable
   task automatic write_csr(input logic idx, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == efhp_pkg::CSR_ETHERTYPE) cfg_ethertype = data;
      else cfg_version = data[7:0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Pick new registers, extremes often; upper version bits are don't-care
   task automatic set_config();
      logic [15:0] etype;
      logic [7:0]  ver;
      wait_idle();
      case ($urandom_range(3))
         0: etype = 16'h0000;
         1: etype = 16'hFFFF;
         default: etype = 16'($urandom);
      endcase
      case ($urandom_range(3))
         0: ver = 8'h00;
         1: ver = 8'hFF;
         default: ver = 8'($urandom);
      endcase
      write_csr(efhp_pkg::CSR_ETHERTYPE, etype);
      write_csr(efhp_pkg::CSR_VERSION, {8'($urandom), ver});
   endtask

   task automatic send_random_frame();
      logic [7:0]  fr[$];
      int unsigned shape;
      int unsigned total;
      logic [15:0] etype;
      logic [7:0]  ver;
      logic [15:0] plen;
      shape = $urandom_range(99);
      etype = ($urandom_range(99) < 8) ? 16'($urandom) : cfg_ethertype;
      ver   = ($urandom_range(99) < 8) ? 8'($urandom) : cfg_version;
      if ($urandom_range(99) < 15) plen = $urandom_range(1) ? 16'hFFFF : 16'($urandom);
      else plen = 16'($urandom_range(24));
      build_header(fr, etype, ver, plen);
      if (shape < 10) begin
         // noise: random bytes, any length
         foreach (fr[i]) fr[i] = 8'($urandom);
         total = $urandom_range(1, 30);
      end else if (shape < 20) begin
         total = $urandom_range(1, 20);
      end else if (shape < 30 && plen != 0 && plen < 25) begin
         // one byte short of the declared payload
         total = 21 + plen - 1;
      end else if (plen < 25) begin
         total = 21 + plen + $urandom_range(3);
      end else begin
         total = 21 + $urandom_range(10);
      end
      while (fr.size() < total) fr.push_back(8'($urandom));
      while (fr.size() > total) void'(fr.pop_back());
      random_items += fr.size();
      send_frame(fr);
   endtask

   // Receiver backpressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Compare each response with the oldest logged one
   always @(posedge clock) begin : response_check
      parse_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (parsed_bytes.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            want = parsed_bytes.pop_front();
            check_field("payload_byte", 64'(want.payload_byte), 64'(rsp_tdata[7:0]));
            check_field("payload_valid", 64'(want.payload_valid), 64'(rsp_tuser));
            check_field("frame_done", 64'(want.frame_done), 64'(rsp_tlast));
            check_field("accepted", 64'(want.accepted), 64'(rsp_tdata[8]));
            check_field("status", 64'(want.status), 64'(rsp_tdata[11:9]));
            check_field("source_mac", 64'(want.source_mac), 64'(rsp_tdata[59:12]));
            check_field("message_type", 64'(want.message_type), 64'(rsp_tdata[67:60]));
            check_field("sequence_res", 64'(want.sequence_res), 64'(rsp_tdata[83:68]));
            check_field("flag_bits", 64'(want.flag_bits), 64'(rsp_tdata[91:84]));
            check_field("payload_length", 64'(want.payload_length),
                        64'(rsp_tdata[107:92]));
            check_field("pad", 64'h0, 64'(rsp_tdata[111:108]));
         end
      end
   end

   // Watchdog: end the run when no request or response moves for too long
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ethernet_frame_header_parser_core_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed bytes with sender and receiver idling
      gap_pct   = 28;
      stall_pct = 55;
      write_csr(efhp_pkg::CSR_ETHERTYPE, 16'hFFFF);
      write_csr(efhp_pkg::CSR_VERSION, 16'h00FF);
      foreach (DIRECTED_ROWS[i]) begin
         send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].eof, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].want);
      end

      // random frames in three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         gap_pct   = (ph == 0) ? 28 : (ph == 1) ? 55 : 0;
         stall_pct = (ph == 0) ? 55 : (ph == 1) ? 28 : 0;
         set_config();
         while (random_items < RANDOM_ITEMS * (ph + 1) / 3) begin
            if ($urandom_range(5) == 0) set_config();
            send_random_frame();
         end
      end

      wait_idle();
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("ethernet_frame_header_parser_core_tb: PASS");
      end else begin
         $display("ethernet_frame_header_parser_core_tb: FAIL");
      end
      $finish;
   end

endmodule
